[design/sitoa_pkg.sv]
// ----------------------------------------------------------------------------
// sitoa_pkg
// shared types, microcode encodings and constants for the integer to
// decimal ascii converter
// ----------------------------------------------------------------------------
package sitoa_pkg;

  localparam int unsigned DataWidthDefault = 32;
  localparam int unsigned CharWidth        = 6;
  localparam int unsigned UpcWidth         = 3;

  localparam logic [CharWidth-1:0] CharZero  = 6'd48;
  localparam logic [CharWidth-1:0] CharMinus = 6'd45;

  // program addresses
  localparam logic [UpcWidth-1:0] StepIdle  = 3'd0;
  localparam logic [UpcWidth-1:0] StepShift = 3'd1;
  localparam logic [UpcWidth-1:0] StepTop   = 3'd2;
  localparam logic [UpcWidth-1:0] StepScan  = 3'd3;
  localparam logic [UpcWidth-1:0] StepSign  = 3'd4;
  localparam logic [UpcWidth-1:0] StepDigit = 3'd5;
  localparam logic [UpcWidth-1:0] StepDone  = 3'd6;

  typedef enum logic [2:0] {
    OpNop,
    OpLoad,
    OpShift,
    OpTop,
    OpScan,
    OpSign,
    OpDigit
  } op_e;

  typedef enum logic [2:0] {
    CondNever,
    CondAlways,
    CondNoStart,
    CondMoreBits,
    CondScan,
    CondMoreDigits
  } cond_e;

  typedef struct packed {
    op_e                 op;
    cond_e               cond;
    logic [UpcWidth-1:0] target;
  } uword_t;

  typedef struct packed {
    logic more_bits;
    logic scan;
    logic more_digits;
  } flags_t;

  // decimal digits of the largest magnitude, 2**(w-1)
  function automatic int unsigned digits_for(input int unsigned w);
    return (((w - 1) * 1233) >> 12) + 1;
  endfunction

endpackage

[design/sitoa_ucode_rom.sv]
// ----------------------------------------------------------------------------
// sitoa_ucode_rom
// control store: one control word per program step
// ----------------------------------------------------------------------------
module sitoa_ucode_rom (
  input  logic [sitoa_pkg::UpcWidth-1:0] addr_i,
  output sitoa_pkg::uword_t              uword_o
);

  always_comb begin
    case (addr_i)
      sitoa_pkg::StepIdle:
        uword_o = '{sitoa_pkg::OpLoad, sitoa_pkg::CondNoStart, sitoa_pkg::StepIdle};
      sitoa_pkg::StepShift:
        uword_o = '{sitoa_pkg::OpShift, sitoa_pkg::CondMoreBits, sitoa_pkg::StepShift};
      sitoa_pkg::StepTop:
        uword_o = '{sitoa_pkg::OpTop, sitoa_pkg::CondNever, sitoa_pkg::StepIdle};
      sitoa_pkg::StepScan:
        uword_o = '{sitoa_pkg::OpScan, sitoa_pkg::CondScan, sitoa_pkg::StepScan};
      sitoa_pkg::StepSign:
        uword_o = '{sitoa_pkg::OpSign, sitoa_pkg::CondNever, sitoa_pkg::StepIdle};
      sitoa_pkg::StepDigit:
        uword_o = '{sitoa_pkg::OpDigit, sitoa_pkg::CondMoreDigits, sitoa_pkg::StepDigit};
      sitoa_pkg::StepDone:
        uword_o = '{sitoa_pkg::OpNop, sitoa_pkg::CondAlways, sitoa_pkg::StepIdle};
      default:
        uword_o = '{sitoa_pkg::OpNop, sitoa_pkg::CondAlways, sitoa_pkg::StepIdle};
    endcase
  end

endmodule

[design/sitoa_sequencer.sv]
// ----------------------------------------------------------------------------
// sitoa_sequencer
// step counter with conditional jumps taken from the control word
// ----------------------------------------------------------------------------
module sitoa_sequencer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  sitoa_pkg::uword_t              uword_i,
  input  sitoa_pkg::flags_t              flags_i,
  output logic [sitoa_pkg::UpcWidth-1:0] upc_o,
  output logic                           busy_o
);

  logic [sitoa_pkg::UpcWidth-1:0] upc_d, upc_q;
  logic                           jump;

  always_comb begin
    case (uword_i.cond)
      sitoa_pkg::CondNever:      jump = 1'b0;
      sitoa_pkg::CondAlways:     jump = 1'b1;
      sitoa_pkg::CondNoStart:    jump = !start_i;
      sitoa_pkg::CondMoreBits:   jump = flags_i.more_bits;
      sitoa_pkg::CondScan:       jump = flags_i.scan;
      sitoa_pkg::CondMoreDigits: jump = flags_i.more_digits;
      default:                   jump = 1'b1;
    endcase
    upc_d = jump ? uword_i.target : upc_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= sitoa_pkg::StepIdle;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign upc_o  = upc_q;
  assign busy_o = (upc_q != sitoa_pkg::StepIdle);

endmodule

[design/sitoa_datapath.sv]
// ----------------------------------------------------------------------------
// sitoa_datapath
// magnitude and bcd registers with shift-add-3 step, digit pointer and
// character output register
// ----------------------------------------------------------------------------
module sitoa_datapath #(
  parameter int unsigned DataWidth = sitoa_pkg::DataWidthDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [DataWidth-1:0]            value_i,
  input  sitoa_pkg::uword_t               uword_i,
  output sitoa_pkg::flags_t               flags_o,
  output logic                            valid_o,
  output logic [sitoa_pkg::CharWidth-1:0] char_code_o,
  output logic                            last_o
);

  localparam int unsigned NumDigits = sitoa_pkg::digits_for(DataWidth);
  localparam int unsigned BcdWidth  = 4 * NumDigits;
  localparam int unsigned CntWidth  = $clog2(DataWidth + 1);
  localparam int unsigned IdxWidth  = $clog2(NumDigits);

  logic [DataWidth-1:0]            mag_q;
  logic [BcdWidth-1:0]             bcd_q, bcd_adj;
  logic                            neg_q;
  logic [CntWidth-1:0]             cnt_q;
  logic [IdxWidth-1:0]             idx_q;
  logic [3:0]                      cur_digit;
  logic                            valid_d, valid_q;
  logic [sitoa_pkg::CharWidth-1:0] char_d, char_q;
  logic                            last_d, last_q;

  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                    : bcd_q[4*i +: 4];
    end
  end

  assign cur_digit           = bcd_q[4*idx_q +: 4];
  assign flags_o.more_bits   = (cnt_q != CntWidth'(1));
  assign flags_o.scan        = (cur_digit == 4'd0) && (idx_q != '0);
  assign flags_o.more_digits = (idx_q != '0);

  always_ff @(posedge clk_i) begin
    case (uword_i.op)
      sitoa_pkg::OpLoad: begin
        neg_q <= value_i[DataWidth-1];
        mag_q <= value_i[DataWidth-1] ? (~value_i + 1'b1) : value_i;
        bcd_q <= '0;
        cnt_q <= CntWidth'(DataWidth);
      end
      sitoa_pkg::OpShift: begin
        {bcd_q, mag_q} <= {bcd_adj[BcdWidth-2:0], mag_q, 1'b0};
        cnt_q          <= cnt_q - 1'b1;
      end
      sitoa_pkg::OpTop: begin
        idx_q <= IdxWidth'(NumDigits - 1);
      end
      sitoa_pkg::OpScan: begin
        if (flags_o.scan) begin
          idx_q <= idx_q - 1'b1;
        end
      end
      sitoa_pkg::OpDigit: begin
        if (flags_o.more_digits) begin
          idx_q <= idx_q - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    valid_d = 1'b0;
    char_d  = sitoa_pkg::CharZero + {2'b00, cur_digit};
    last_d  = 1'b0;
    case (uword_i.op)
      sitoa_pkg::OpSign: begin
        valid_d = neg_q;
        char_d  = sitoa_pkg::CharMinus;
      end
      sitoa_pkg::OpDigit: begin
        valid_d = 1'b1;
        last_d  = (idx_q == '0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
  end

  assign valid_o     = valid_q;
  assign char_code_o = char_q;
  assign last_o      = last_q;

endmodule

[design/signed_int_to_decimal_ascii.sv]
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// converts a signed integer into its decimal ascii characters, sign first,
// most significant digit first, last flag on the final character
// ----------------------------------------------------------------------------
// channel   direction  handshake           payload
// command   in         start_i, busy_o     value_i
// result    out        valid_o strobe      char_code_o, last_o
//
// a transaction is accepted when start_i is high and busy_o is low
// every command runs one shift-add-3 step per input bit, the leading zero
// scan and one character per step of the microcode sequencer
// results are strobed for one cycle each; the receiver cannot stall
// reset clears the step counter and the result strobe
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii #(
  parameter int unsigned DataWidth = sitoa_pkg::DataWidthDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [DataWidth-1:0]            value_i,
  output logic                            valid_o,
  output logic [sitoa_pkg::CharWidth-1:0] char_code_o,
  output logic                            last_o
);

  logic [sitoa_pkg::UpcWidth-1:0] upc;
  sitoa_pkg::uword_t              uword;
  sitoa_pkg::flags_t              flags;

  sitoa_ucode_rom u_rom (
    .addr_i  (upc),
    .uword_o (uword)
  );

  sitoa_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .uword_i (uword),
    .flags_i (flags),
    .upc_o   (upc),
    .busy_o  (busy_o)
  );

  sitoa_datapath #(
    .DataWidth (DataWidth)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (value_i),
    .uword_i     (uword),
    .flags_o     (flags),
    .valid_o     (valid_o),
    .char_code_o (char_code_o),
    .last_o      (last_o)
  );

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives signed integers into the decimal ascii converter in random bursts
// and checks every strobed character and last flag against a directed
// table's text of extremes and digit boundaries or a local conversion model
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned DataWidth   = sitoa_pkg::DataWidthDefault;
  localparam int          RandomItems = 410;
  localparam int          IdleLimit   = 2000;
  localparam int          DrainCycles = 60;

  typedef struct packed {
    logic [sitoa_pkg::CharWidth-1:0] code;
    logic                            last;
  } char_t;

  typedef struct {
    logic [DataWidth-1:0] value;
    string                text;
  } vector_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            start_i;
  logic                            busy_o;
  logic [DataWidth-1:0]            value_i;
  logic                            valid_o;
  logic [sitoa_pkg::CharWidth-1:0] char_code_o;
  logic                            last_o;

  char_t char_fifo[$];
  char_t expected_char;
  int    errors;
  int    idle_cycles;
  int    burst_left;

  // empty text means the row is checked against the conversion model
  vector_t directed[] = '{
    '{32'd0,           "0"},
    '{32'd1,           "1"},
    '{-32'sd1,         "-1"},
    '{32'd7,           "7"},
    '{32'd9,           "9"},
    '{32'd10,          "10"},
    '{-32'sd10,        "-10"},
    '{-32'sd100,       "-100"},
    '{32'd12345,       "12345"},
    '{32'd999999999,   "999999999"},
    '{-32'sd999999999, "-999999999"},
    '{32'd1000000000,  "1000000000"},
    '{32'h7fffffff,    "2147483647"},
    '{32'h80000000,    "-2147483648"},
    '{32'h80000001,    "-2147483647"},
    '{32'h55555555,    ""},
    '{32'haaaaaaaa,    ""},
    '{32'h0000ffff,    ""},
    '{32'hffff0000,    ""},
    '{32'h0000ffff,    ""}
  };

  signed_int_to_decimal_ascii #(
    .DataWidth(DataWidth)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .value_i    (value_i),
    .valid_o    (valid_o),
    .char_code_o(char_code_o),
    .last_o     (last_o)
  );

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic void predict_chars(input logic [DataWidth-1:0] value);
    logic [DataWidth-1:0] mag;
    logic [3:0]           digit_buf[24];
    int                   ndigits;
    char_t                c;
    mag = value[DataWidth-1] ? -value : value;
    ndigits = 0;
    do begin
      digit_buf[ndigits] = 4'(mag % 10);
      ndigits++;
      mag = mag / 10;
    end while (mag != 0);
    if (value[DataWidth-1]) begin
      c.code = sitoa_pkg::CharMinus;
      c.last = 1'b0;
      char_fifo.push_back(c);
    end
    for (int k = ndigits - 1; k >= 0; k--) begin
      c.code = sitoa_pkg::CharZero + sitoa_pkg::CharWidth'(digit_buf[k]);
      c.last = (k == 0);
      char_fifo.push_back(c);
    end
  endfunction

  function automatic void push_text(input string text);
    char_t c;
    byte   ch;
    for (int i = 0; i < text.len(); i++) begin
      ch     = text[i];
      c.code = ch[sitoa_pkg::CharWidth-1:0];
      c.last = (i == text.len() - 1);
      char_fifo.push_back(c);
    end
  endfunction

  function automatic logic [DataWidth-1:0] random_value();
    logic [DataWidth-1:0] v;
    logic [DataWidth-1:0] pow10;
    int                   k;
    case ($urandom_range(0, 5))
      0, 1: v = $urandom;
      2: v = $urandom_range(0, 99);
      3: begin
        k = $urandom_range(0, 9);
        pow10 = 1;
        repeat (k) pow10 = pow10 * 10;
        v = pow10 + DataWidth'($urandom_range(0, 2)) - 1;
      end
      4: begin
        case ($urandom_range(0, 4))
          0: v = '0;
          1: v = {1'b0, {(DataWidth-1){1'b1}}};
          2: v = {1'b1, {(DataWidth-1){1'b0}}};
          3: v = '1;
          default: v = 1;
        endcase
      end
      default: v = $urandom_range(0, 65535);
    endcase
    if ($urandom_range(0, 1) == 1) begin
      v = -v;
    end
    return v;
  endfunction

  // holds start until the transaction is taken, then idles between bursts
  task automatic send_value(input logic [DataWidth-1:0] v, input string text);
    start_i <= 1'b1;
    value_i <= v;
    do @(posedge clk_i); while (busy_o);
    if (text.len() != 0) begin
      push_text(text);
    end else begin
      predict_chars(v);
    end
    if (burst_left == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 60)) @(posedge clk_i);
      burst_left = $urandom_range(0, 15);
    end else begin
      burst_left--;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (char_fifo.size() == 0) begin
        $error("unexpected result char_code=%0d last=%0d", char_code_o, last_o);
        errors++;
      end else begin
        expected_char = char_fifo.pop_front();
        if (char_code_o !== expected_char.code) begin
          $error("char_code expected %0d actual %0d", expected_char.code, char_code_o);
          errors++;
        end
        if (last_o !== expected_char.last) begin
          $error("last expected %0d actual %0d", expected_char.last, last_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || valid_o || (start_i && !busy_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < IdleLimit) @(posedge clk_i);
    $display("timeout with %0d characters outstanding", char_fifo.size());
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    value_i     = '0;
    burst_left  = $urandom_range(0, 15);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      send_value(directed[i].value, directed[i].text);
    end
    repeat (RandomItems) begin
      send_value(random_value(), "");
    end
    start_i <= 1'b0;

    while (char_fifo.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
